[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/dqc_pkg.sv]
`default_nettype none

package dqc_pkg;
	localparam int WINDOW_W = 24;
	localparam int TIMER_W = 25;
	localparam int NET_W = 16;
	localparam int COUNT_BITS_DEFAULT = 16;
	localparam logic [WINDOW_W-1:0] DEBOUNCE_RESET = 24'd150000;
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
endpackage

`default_nettype wire

[design/debounced_quadrature_counter.sv]
// Quadrature decoder with per-channel debounce lockout. One item is one sampled tick of
// channels A and B plus a read request; an item is taken every clock cycle, the only stall
// being a read result still waiting in the output register. Falling edges on A or B step a
// wrapping COUNT_BITS-wide net count, each channel ignoring edges until more than
// debounce_window ticks have passed since its last accepted edge (timers are 25 bits and
// saturate; they start at zero, so edges are locked out right after reset). A read returns
// the low 16 bits of the count from before the tick in the next cycle, and clears it; edges
// in the same tick land in the new count. debounce_window resets to 150000 and is written
// through the cfg channel, which is always ready.
`default_nettype none

module debounced_quadrature_counter
	import dqc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [WINDOW_W-1:0]        debounce_window,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       level_a,
	input  wire logic                       level_b,
	input  wire logic                       read_request,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [NET_W-1:0]         net_steps
);

	logic [WINDOW_W-1:0]   window_q;
	logic                  prev_a_q;
	logic                  prev_b_q;
	logic [TIMER_W-1:0]    since_a_q;
	logic [TIMER_W-1:0]    since_b_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;
	logic [NET_W-1:0]      net_q;

	logic                  in_take;
	logic                  pass_a;
	logic                  pass_b;
	logic [TIMER_W-1:0]    since_a_next;
	logic [TIMER_W-1:0]    since_b_next;
	logic [COUNT_BITS-1:0] base;
	logic [COUNT_BITS-1:0] step_a;
	logic [COUNT_BITS-1:0] step_b;
	logic [COUNT_BITS-1:0] count_next;
	logic [31:0]           count_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_take   = in_valid && in_ready;

	// lockout compares against the timer value from before this tick
	assign pass_a = prev_a_q && !level_a && (since_a_q > {1'b0, window_q});
	assign pass_b = prev_b_q && !level_b && (since_b_q > {1'b0, window_q});

	always_comb begin
		if (pass_a) begin
			since_a_next = '0;
		end else if (since_a_q == TIMER_MAX) begin
			since_a_next = since_a_q;
		end else begin
			since_a_next = since_a_q + 1'b1;
		end
		if (pass_b) begin
			since_b_next = '0;
		end else if (since_b_q == TIMER_MAX) begin
			since_b_next = since_b_q;
		end else begin
			since_b_next = since_b_q + 1'b1;
		end
	end

	// A: up when B low; B: up when A high. Down is +all-ones.
	always_comb begin
		base   = read_request ? '0 : count_q;
		step_a = '0;
		step_b = '0;
		if (pass_a) begin
			step_a = level_b ? {COUNT_BITS{1'b1}} : COUNT_BITS'(1);
		end
		if (pass_b) begin
			step_b = level_a ? COUNT_BITS'(1) : {COUNT_BITS{1'b1}};
		end
		count_next = base + step_a + step_b;
	end

	// zero-extend narrow counts before taking the low result bits
	assign count_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			window_q <= debounce_window;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q  <= 1'b1;
			prev_b_q  <= 1'b1;
			since_a_q <= '0;
			since_b_q <= '0;
			count_q   <= '0;
		end else if (in_take) begin
			prev_a_q  <= level_a;
			prev_b_q  <= level_b;
			since_a_q <= since_a_next;
			since_b_q <= since_b_next;
			count_q   <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && read_request) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && read_request) begin
			net_q <= count_ext[NET_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign net_steps = signed'(net_q);

endmodule

`default_nettype wire

[design/dqc_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module dqc_checker
	import dqc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 read_request,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic signed [NET_W-1:0] net_steps
);

	// a held result must not change before it is taken
	`DQC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(net_steps))

	// an empty output stage never blocks input items
	`DQC_ASSERT_SAME(a_in_free, clk, arst_n, !out_valid, in_ready)

	// every read item yields a result next cycle
	`DQC_ASSERT_NEXT(a_read_result, clk, arst_n, in_valid && in_ready && read_request, out_valid)

	// no result appears without a read
	`DQC_ASSERT_NEXT(a_no_phantom, clk, arst_n,
		(!out_valid || out_ready) && !(in_valid && in_ready && read_request), !out_valid)

endmodule

bind debounced_quadrature_counter dqc_checker u_dqc_checker (.*);

`default_nettype wire
